FILE: rtl/fnvlp_pkg.sv
package fnvlp_pkg;

	localparam int SLOTS        = 1024;
	localparam int SLOT_W       = $clog2(SLOTS);
	localparam int COUNT_W      = SLOT_W + 1;
	localparam int KEY_BYTES    = 4;
	localparam int BYTE_IDX_W   = 3;
	localparam int KEY_W        = 32;
	localparam int VALUE_W      = 32;
	localparam int SLOT_FIELD_W = 10;

	localparam logic [31:0] FNV_OFFSET = 32'h811c9dc5;
	localparam logic [31:0] FNV_PRIME  = 32'h01000193;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FOUND    = 2'd1,
		ST_MISSING  = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    clr_step;
		logic    load;
		logic    hash_step;
		logic    probe_adv;
		logic    ins_write;
		logic    out_load;
		status_t out_status;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic clr_last;
		logic hash_last;
		logic lookup;
		logic full;
		logic occ;
		logic match;
		logic probe_last;
		logic out_busy;
	} sts_t;

endpackage

FILE: rtl/fnvlp_req_if.sv
interface fnvlp_req_if;
	logic                             valid;
	logic                             ready;
	fnvlp_pkg::op_t                   op;
	logic [fnvlp_pkg::KEY_W-1:0]      key;
	logic [fnvlp_pkg::VALUE_W-1:0]    value;

	modport source (output valid, output op, output key, output value, input ready);
	modport sink   (input valid, input op, input key, input value, output ready);
endinterface

FILE: rtl/fnvlp_rsp_if.sv
interface fnvlp_rsp_if;
	logic                                valid;
	logic                                ready;
	fnvlp_pkg::status_t                  status;
	logic [fnvlp_pkg::VALUE_W-1:0]       found_value;
	logic [fnvlp_pkg::SLOT_FIELD_W-1:0]  slot;

	modport source (output valid, output status, output found_value, output slot,
		input ready);
	modport sink   (input valid, input status, input found_value, input slot,
		output ready);
endinterface

FILE: rtl/fnvlp_ram.sv
module fnvlp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/fnvlp_ctrl.sv
module fnvlp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  fnvlp_pkg::sts_t   sts,
	output fnvlp_pkg::cmd_t   cmd
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_HASH  = 6'b000100,
		S_READ  = 6'b001000,
		S_CHECK = 6'b010000,
		S_DONE  = 6'b100000
	} state_t;

	state_t             state_q, state_d;
	fnvlp_pkg::status_t res_q, res_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d        = state_q;
		res_d          = res_q;
		cmd            = '0;
		cmd.out_status = res_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_step = 1'b1;
				if (sts.hash_last) begin
					if (!sts.lookup && sts.full) begin
						res_d   = fnvlp_pkg::ST_FULL;
						state_d = S_DONE;
					end else begin
						state_d = S_READ;
					end
				end
			end
			S_READ: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (sts.lookup) begin
					if (!sts.occ) begin
						res_d   = fnvlp_pkg::ST_MISSING;
						state_d = S_DONE;
					end else if (sts.match) begin
						res_d   = fnvlp_pkg::ST_FOUND;
						state_d = S_DONE;
					end else if (sts.probe_last) begin
						res_d   = fnvlp_pkg::ST_MISSING;
						state_d = S_DONE;
					end else begin
						cmd.probe_adv = 1'b1;
						state_d       = S_READ;
					end
				end else begin
					if (!sts.occ) begin
						cmd.ins_write = 1'b1;
						res_d         = fnvlp_pkg::ST_INSERTED;
						state_d       = S_DONE;
					end else if (sts.probe_last) begin
						res_d   = fnvlp_pkg::ST_FULL;
						state_d = S_DONE;
					end else begin
						cmd.probe_adv = 1'b1;
						state_d       = S_READ;
					end
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

endmodule

FILE: rtl/fnvlp_dpath.sv
module fnvlp_dpath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fnvlp_pkg::cmd_t                     cmd,
	output fnvlp_pkg::sts_t                     sts,
	input  fnvlp_pkg::op_t                      in_op,
	input  logic [fnvlp_pkg::KEY_W-1:0]         in_key,
	input  logic [fnvlp_pkg::VALUE_W-1:0]       in_value,
	output logic                                out_valid,
	input  logic                                out_ready,
	output fnvlp_pkg::status_t                  out_status,
	output logic [fnvlp_pkg::VALUE_W-1:0]       out_found_value,
	output logic [fnvlp_pkg::SLOT_FIELD_W-1:0]  out_slot
);

	localparam int KV_W = fnvlp_pkg::KEY_W + fnvlp_pkg::VALUE_W;

	fnvlp_pkg::op_t                       op_q;
	logic [fnvlp_pkg::KEY_W-1:0]          key_q;
	logic [fnvlp_pkg::VALUE_W-1:0]        value_q;
	logic [31:0]                          hash_q;
	logic [fnvlp_pkg::BYTE_IDX_W-1:0]     bidx_q;
	logic [fnvlp_pkg::SLOT_W-1:0]         pos_q;
	logic [fnvlp_pkg::SLOT_W-1:0]         probe_n_q;
	logic [fnvlp_pkg::COUNT_W-1:0]        count_q;
	logic                                 out_valid_q;
	fnvlp_pkg::status_t                   out_status_q;
	logic [fnvlp_pkg::VALUE_W-1:0]        out_value_q;
	logic [fnvlp_pkg::SLOT_FIELD_W-1:0]   out_slot_q;

	logic [63:0]  key_ext;
	logic [7:0]   key_byte;
	logic [31:0]  hash_next;
	logic         occ_rd;
	logic [KV_W-1:0] kv_rd;

	// Bytes above the key width hash as zero.
	assign key_ext   = {{(64 - fnvlp_pkg::KEY_W){1'b0}}, key_q};
	assign key_byte  = key_ext[{bidx_q, 3'b000} +: 8];
	assign hash_next = (hash_q ^ {24'b0, key_byte}) * fnvlp_pkg::FNV_PRIME;

	fnvlp_ram #(.WIDTH(1), .DEPTH(fnvlp_pkg::SLOTS)) u_occ_ram (
		.clk   (clk),
		.we    (cmd.clr_step | cmd.ins_write),
		.waddr (pos_q),
		.wdata (cmd.ins_write),
		.raddr (pos_q),
		.rdata (occ_rd)
	);

	fnvlp_ram #(.WIDTH(KV_W), .DEPTH(fnvlp_pkg::SLOTS)) u_kv_ram (
		.clk   (clk),
		.we    (cmd.ins_write),
		.waddr (pos_q),
		.wdata ({key_q, value_q}),
		.raddr (pos_q),
		.rdata (kv_rd)
	);

	assign sts.clr_last   = (pos_q == fnvlp_pkg::SLOT_W'(fnvlp_pkg::SLOTS - 1));
	assign sts.hash_last  = (bidx_q == fnvlp_pkg::BYTE_IDX_W'(fnvlp_pkg::KEY_BYTES - 1));
	assign sts.lookup     = (op_q == fnvlp_pkg::OP_LOOKUP);
	assign sts.full       = (count_q == fnvlp_pkg::COUNT_W'(fnvlp_pkg::SLOTS));
	assign sts.occ        = occ_rd;
	assign sts.match      = (kv_rd[KV_W-1:fnvlp_pkg::VALUE_W] == key_q);
	assign sts.probe_last = (probe_n_q == fnvlp_pkg::SLOT_W'(fnvlp_pkg::SLOTS - 1));
	assign sts.out_busy   = out_valid_q & ~out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= in_op;
			key_q   <= in_key;
			value_q <= in_value;
			hash_q  <= fnvlp_pkg::FNV_OFFSET;
			bidx_q  <= '0;
		end else if (cmd.hash_step) begin
			hash_q <= hash_next;
			bidx_q <= bidx_q + 1'b1;
		end
		if (cmd.hash_step) begin
			probe_n_q <= '0;
		end else if (cmd.probe_adv) begin
			probe_n_q <= probe_n_q + 1'b1;
		end
		if (cmd.out_load) begin
			out_status_q <= cmd.out_status;
			out_value_q  <= (cmd.out_status == fnvlp_pkg::ST_FOUND)
				? kv_rd[fnvlp_pkg::VALUE_W-1:0] : '0;
			out_slot_q   <= (cmd.out_status == fnvlp_pkg::ST_FOUND ||
				cmd.out_status == fnvlp_pkg::ST_INSERTED)
				? fnvlp_pkg::SLOT_FIELD_W'(pos_q) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.hash_step && sts.hash_last) begin
				pos_q <= hash_next[fnvlp_pkg::SLOT_W-1:0];
			end else if (cmd.clr_step || cmd.probe_adv) begin
				pos_q <= pos_q + 1'b1;
			end
			if (cmd.ins_write) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid       = out_valid_q;
	assign out_status      = out_status_q;
	assign out_found_value = out_value_q;
	assign out_slot        = out_slot_q;

endmodule

FILE: rtl/fnv_linear_probe_hash_map.sv
// One item at a time: a new input transfer is taken only once the previous result is loaded.
// Each item is hashed by four chained FNV multiplies and needs one registered read per probe.
// Reset: asynchronous, active low; afterwards the occupancy RAM is cleared in a
// pass over all 1024 slots (one slot per cycle) during which no input transfer is taken.
module fnv_linear_probe_hash_map (
	input  logic       clk,
	input  logic       arst_n,
	fnvlp_req_if.sink  req,
	fnvlp_rsp_if.source rsp
);

	fnvlp_pkg::cmd_t cmd;
	fnvlp_pkg::sts_t sts;

	// The controller sequences the clearing pass, the byte-wise hash, the
	// probe loop and the hand-off into the result register.
	fnvlp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the captured item, the hash register, the probe
	// pointer, the entry count, the slot RAMs and the result register. The
	// result register lets a finished result wait while the next item is
	// taken in and hashed; the controller only stalls at its final step.
	fnvlp_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_op           (req.op),
		.in_key          (req.key),
		.in_value        (req.value),
		.out_valid       (rsp.valid),
		.out_ready       (rsp.ready),
		.out_status      (rsp.status),
		.out_found_value (rsp.found_value),
		.out_slot        (rsp.slot)
	);

	// An insert never writes into a table whose entry count is at capacity.
	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_write |-> !sts.full)
		else $error("insert write while table full");

	// Only one item is in flight: an input transfer is followed by a busy cycle.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("input accepted while an item is in flight");

	// A new result is loaded only when the previous one has left or is leaving.
	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_busy)
		else $error("result register overwritten before transfer");

	// Nothing is taken in while the occupancy clearing pass may still be running.
	a_clear_before_use: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !req.ready)
		else $error("input ready during clearing pass");

endmodule
